FILE: rtl/core/assf_pkg.sv
// Shared types, codes and segment constants for the auto-ranging
// seven-segment formatter. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package assf_pkg;

    // display_mode register codes
    localparam logic [1:0] MODE_METER = 2'd0;
    localparam logic [1:0] MODE_ANGLE = 2'd1;
    localparam logic [1:0] MODE_CAL   = 2'd2;

    // calibration_page register codes
    localparam logic [1:0] PAGE_NORMAL = 2'd0;
    localparam logic [1:0] PAGE_ONE    = 2'd1;
    localparam logic [1:0] PAGE_TWO    = 2'd2;
    localparam logic [1:0] PAGE_THREE  = 2'd3;

    // config register indexes
    localparam logic [1:0] REG_DISPLAY_MODE = 2'd0;
    localparam logic [1:0] REG_CAL_PAGE     = 2'd1;

    // segment patterns (bit 0 = a .. bit 6 = g, bit 7 = point)
    localparam logic [7:0] SEG_DP    = 8'h80;
    localparam logic [7:0] SEG_ZERO  = 8'h3F;
    localparam logic [7:0] SEG_P     = 8'h73;
    localparam logic [7:0] SEG_R     = 8'h50;
    localparam logic [7:0] SEG_BLANK = 8'h00;
    localparam logic [7:0] SEG_T     = 8'h78;
    localparam logic [7:0] SEG_A     = 8'h77;
    localparam logic [7:0] SEG_Y     = 8'h6E;

    // request from the range logic to one renderer
    typedef struct packed {
        logic [15:0] scaled;  // already wrapped to 16 bits
        logic [1:0]  point;   // digit carrying the decimal point
    } t_render_req;

    function automatic logic [7:0] seg7(input logic [3:0] digit);
        logic [7:0] p;
        case (digit)
            4'd0:    p = 8'h3F;
            4'd1:    p = 8'h06;
            4'd2:    p = 8'h5B;
            4'd3:    p = 8'h4F;
            4'd4:    p = 8'h66;
            4'd5:    p = 8'h6D;
            4'd6:    p = 8'h7D;
            4'd7:    p = 8'h07;
            4'd8:    p = 8'h7F;
            4'd9:    p = 8'h6F;
            default: p = 8'h00;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/assf_render.sv
// Renders a 16-bit scaled value as four seven-segment patterns with a point.
// Depends on assf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module assf_render
    import assf_pkg::*;
(
    input  wire t_render_req      i_req,
    output logic [3:0][7:0]       o_pat   // [0] most significant digit
);

    logic [15:0] wrap_sub;
    logic [13:0] rem4;
    logic [13:0] rem3;
    logic [13:0] rem2;
    logic [3:0]  dig0;
    logic [3:0]  dig1;
    logic [3:0]  dig2;
    logic [3:0]  dig3;
    logic [13:0] sub3;
    logic [13:0] sub2;
    logic [13:0] sub1;

    // low four decimal digits: parallel compares per digit, then subtract
    always_comb begin
        wrap_sub = 16'd0;
        for (int k = 1; k <= 6; k++) begin
            if (i_req.scaled >= 16'(k * 10000)) wrap_sub = 16'(k * 10000);
        end
        rem4 = 14'(i_req.scaled - wrap_sub);

        dig0 = 4'd0;
        sub3 = 14'd0;
        for (int k = 1; k <= 9; k++) begin
            if (rem4 >= 14'(k * 1000)) begin
                dig0 = 4'(k);
                sub3 = 14'(k * 1000);
            end
        end
        rem3 = rem4 - sub3;

        dig1 = 4'd0;
        sub2 = 14'd0;
        for (int k = 1; k <= 9; k++) begin
            if (rem3 >= 14'(k * 100)) begin
                dig1 = 4'(k);
                sub2 = 14'(k * 100);
            end
        end
        rem2 = rem3 - sub2;

        dig2 = 4'd0;
        sub1 = 14'd0;
        for (int k = 1; k <= 9; k++) begin
            if (rem2 >= 14'(k * 10)) begin
                dig2 = 4'(k);
                sub1 = 14'(k * 10);
            end
        end
        dig3 = 4'(rem2 - sub1);
    end

    always_comb begin
        o_pat[0] = seg7(dig0);
        o_pat[1] = seg7(dig1);
        o_pat[2] = seg7(dig2);
        o_pat[3] = seg7(dig3);
        o_pat[i_req.point] = o_pat[i_req.point] | SEG_DP;
    end

endmodule

`default_nettype wire

FILE: rtl/core/autorange_seven_segment_formatter.sv
// Top level of the auto-ranging seven-segment formatter: range logic,
// pattern store and stream handshakes. Depends on assf_pkg, assf_render.
`timescale 1ns / 1ps
`default_nettype none

// Takes beats, each carrying a left and a right value (0..9999), and
// returns one beat with eight segment patterns, left digits first, most
// significant digit of each side first, bit 7 of a pattern being the decimal
// point. A beat is caught in an input register when it is accepted and moves
// on into the pattern register, which drives o_m_tvalid and o_m_tdata, once
// that register is empty or being drained; throughput is one beat per
// clock while the output is not stalled. A stalled output holds the pattern
// register and one more beat waits in the input register before o_s_tready
// drops. The scale (x1000/x100/x10/x1) and point position follow
// from the magnitude and display_mode; a value out of range leaves that
// side's previous patterns in place (all zeros with no point after reset).
// A nonzero calibration_page overrides the mode: the right side shows a
// fixed legend, the left side meter or x10 formatting. Calibration mode and
// the unused mode three leave both sides unchanged on page zero.
// Configuration is taken in any cycle (o_cfg_ready is tied high) and is
// expected only while the block is idle; unknown indexes are ignored.
module autorange_seven_segment_formatter
    import assf_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    // input stream
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [31:0] i_s_tdata,   // [13:0] left_value, [27:14] right_value
    // output stream
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [63:0] o_m_tdata,   // left_digit0..3 then right_digit0..3,
                                     // 8 bits each from bit 0 up
    // config write channel
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [1:0]  i_cfg_addr,
    input  wire  [1:0]  i_cfg_data
);

    // config registers
    logic [1:0] r_mode;
    logic [1:0] r_page;

    // input stage
    logic        r_in_valid;
    logic [13:0] r_lv;
    logic [13:0] r_rv;

    // pattern store doubles as the output register
    logic            r_out_valid;
    logic [7:0][7:0] r_pat;
    logic [7:0][7:0] n_pat;

    logic advance;

    t_render_req     left_req;
    t_render_req     right_req;
    logic            left_en;
    logic            right_en;
    logic            legend_en;
    logic [7:0]      legend_last;
    logic [3:0][7:0] left_pat;
    logic [3:0][7:0] right_pat;

    logic [15:0] lv_x1, lv_x10, lv_x100, lv_x1000;
    logic [15:0] rv_x1, rv_x10, rv_x100, rv_x1000;

    // handshakes: pattern register only changes when its beat is gone
    assign advance     = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready  = !r_in_valid || advance;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_pat;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_METER;
            r_page <= PAGE_NORMAL;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                REG_DISPLAY_MODE: r_mode <= i_cfg_data;
                REG_CAL_PAGE:     r_page <= i_cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_lv <= i_s_tdata[13:0];
            r_rv <= i_s_tdata[27:14];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pat       <= {8{SEG_ZERO}};
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                r_pat       <= n_pat;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // scaled candidates, 16-bit wrap
    always_comb begin
        lv_x1    = {2'b00, r_lv};
        lv_x10   = 16'(lv_x1 * 16'd10);
        lv_x100  = 16'(lv_x1 * 16'd100);
        lv_x1000 = 16'(lv_x1 * 16'd1000);
        rv_x1    = {2'b00, r_rv};
        rv_x10   = 16'(rv_x1 * 16'd10);
        rv_x100  = 16'(rv_x1 * 16'd100);
        rv_x1000 = 16'(rv_x1 * 16'd1000);
    end

    // range selection
    always_comb begin
        left_en     = 1'b0;
        right_en    = 1'b0;
        legend_en   = 1'b0;
        legend_last = SEG_T;
        left_req    = '{scaled: lv_x10, point: 2'd0};
        right_req   = '{scaled: rv_x10, point: 2'd0};

        unique case (r_page)
            PAGE_NORMAL: begin
                unique case (r_mode)
                    MODE_METER: begin
                        left_en  = (r_lv < 14'd1000);
                        if (r_lv < 14'd10)       left_req = '{lv_x1000, 2'd0};
                        else if (r_lv < 14'd100) left_req = '{lv_x100, 2'd1};
                        else                     left_req = '{lv_x10, 2'd2};
                        right_en = (r_rv < 14'd1000);
                        if (r_rv < 14'd10)       right_req = '{rv_x1000, 2'd0};
                        else if (r_rv < 14'd100) right_req = '{rv_x100, 2'd1};
                        else                     right_req = '{rv_x10, 2'd2};
                    end
                    MODE_ANGLE: begin
                        left_en  = (r_lv < 14'd9900);
                        if (r_lv < 14'd1000)     left_req = '{lv_x10, 2'd0};
                        else                     left_req = '{lv_x1, 2'd1};
                        right_en = (r_rv < 14'd10000);
                        if (r_rv < 14'd100)       right_req = '{rv_x100, 2'd0};
                        else if (r_rv < 14'd1000) right_req = '{rv_x10, 2'd1};
                        else                      right_req = '{rv_x1, 2'd2};
                    end
                    default: ;  // calibration and unused mode hold both sides
                endcase
            end
            PAGE_ONE: begin
                left_en   = (r_lv < 14'd1000);
                if (r_lv < 14'd10)       left_req = '{lv_x1000, 2'd0};
                else if (r_lv < 14'd100) left_req = '{lv_x100, 2'd1};
                else                     left_req = '{lv_x10, 2'd2};
                legend_en = 1'b1;
            end
            PAGE_TWO: begin
                left_en     = 1'b1;
                legend_en   = 1'b1;
                legend_last = SEG_A;
            end
            PAGE_THREE: begin
                left_en     = 1'b1;
                legend_en   = 1'b1;
                legend_last = SEG_Y;
            end
            default: ;
        endcase
    end

    assf_render u_left (
        .i_req (left_req),
        .o_pat (left_pat)
    );

    assf_render u_right (
        .i_req (right_req),
        .o_pat (right_pat)
    );

    always_comb begin
        n_pat = r_pat;
        if (left_en) begin
            for (int i = 0; i < 4; i++) n_pat[i] = left_pat[i];
        end
        if (legend_en) begin
            n_pat[4] = SEG_P;
            n_pat[5] = SEG_R;
            n_pat[6] = SEG_BLANK;
            n_pat[7] = legend_last;
        end else if (right_en) begin
            for (int i = 0; i < 4; i++) n_pat[4 + i] = right_pat[i];
        end
    end

`ifndef SYNTHESIS
    // a full input stage that cannot drain keeps its beat
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_lv) && $stable(r_rv))
        else $error("input stage lost or changed a beat while stalled");

    // any calibration page puts the legend on the right side
    a_legend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_page != PAGE_NORMAL |=> r_pat[4] == SEG_P && r_pat[5] == SEG_R)
        else $error("calibration legend missing");

    // at most one decimal point per side
    a_left_dp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({r_pat[0][7], r_pat[1][7], r_pat[2][7], r_pat[3][7]}) <= 1)
        else $error("more than one point on left side");

    a_right_dp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({r_pat[4][7], r_pat[5][7], r_pat[6][7], r_pat[7][7]}) <= 1)
        else $error("more than one point on right side");
`endif

endmodule

`default_nettype wire
